FILE: design/mmcs_pkg.sv
// Shared types and constants for the min/max contrast stretch block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mmcs_pkg;

   // Width of a grey level on the ports.
   localparam int PIX_W = 8;
   // Width of the divisor 2*(high-low), which is at most 510.
   localparam int DIV_W = PIX_W + 1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic track;   // measure item accepted: update running range
      logic load;    // map item accepted: classify pixel and form dividend
      logic prep;    // seed partial remainder from the dividend
      logic step;    // one restoring division step
      logic emit;    // write the result into the output register
   } mmcs_cmd_type;

endpackage

`default_nettype wire

FILE: design/mmcs_dp.sv
// Datapath of the contrast stretch: range tracking, dividend formation,
// a bit-serial restoring divider and the output register. Uses mmcs_pkg.
`default_nettype none

module mmcs_dp #(
   parameter int PIXEL_MAX = 255
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mmcs_pkg::mmcs_cmd_type     cmd,
   input  wire logic [mmcs_pkg::PIX_W-1:0] req_pixel,
   input  wire logic                       req_last,
   output logic      [mmcs_pkg::PIX_W-1:0] rsp_pixel_out
);
   import mmcs_pkg::*;

   // Quotient bits: the quotient of an in-range pixel never exceeds PIXEL_MAX.
   localparam int QW    = $clog2(PIXEL_MAX + 1);
   localparam int NUM_W = QW + DIV_W;
   localparam logic [NUM_W-1:0] TWO_PM  = NUM_W'(2 * PIXEL_MAX);
   localparam logic [PIX_W-1:0] MAX_OUT = PIX_W'(PIXEL_MAX);

   typedef enum logic [1:0] {SEL_PASS, SEL_ZERO, SEL_MAX, SEL_QUOT} sel_type;

   logic [PIX_W-1:0] run_lo_ff, run_lo_in, run_hi_ff, run_hi_in;
   logic [PIX_W-1:0] frz_lo_ff, frz_lo_in, frz_hi_ff, frz_hi_in;
   logic             restart_ff, restart_in;

   logic [PIX_W-1:0] pix_ff, pix_in;
   sel_type          sel_ff, sel_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [PIX_W-1:0] pixel_out_ff, pixel_out_in;

   logic [PIX_W-1:0] trk_lo, trk_hi;
   logic [PIX_W-1:0] diff, span;
   logic [DIV_W:0]   shifted;
   logic [DIV_W+1:0] trial;
   logic             fits;

   // Range tracking for measure items.
   always_comb begin
      if (restart_ff) begin
         trk_lo = req_pixel;
         trk_hi = req_pixel;
      end else begin
         trk_lo = (req_pixel < run_lo_ff) ? req_pixel : run_lo_ff;
         trk_hi = (req_pixel > run_hi_ff) ? req_pixel : run_hi_ff;
      end
      run_lo_in  = run_lo_ff;
      run_hi_in  = run_hi_ff;
      frz_lo_in  = frz_lo_ff;
      frz_hi_in  = frz_hi_ff;
      restart_in = restart_ff;
      if (cmd.track) begin
         run_lo_in  = trk_lo;
         run_hi_in  = trk_hi;
         restart_in = req_last;
         if (req_last) begin
            frz_lo_in = trk_lo;
            frz_hi_in = trk_hi;
         end
      end
   end

   // Map item set-up, division steps and result selection.
   always_comb begin
      diff    = req_pixel - frz_lo_ff;
      span    = frz_hi_ff - frz_lo_ff;
      shifted = {rem_ff, quo_ff[QW-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      fits    = !trial[DIV_W+1];

      pix_in       = pix_ff;
      sel_in       = sel_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      pixel_out_in = pixel_out_ff;

      if (cmd.load) begin
         pix_in = req_pixel;
         priority if (frz_hi_ff <= frz_lo_ff) begin
            sel_in = SEL_PASS;
         end else if (req_pixel < frz_lo_ff) begin
            sel_in = SEL_ZERO;
         end else if (req_pixel >= frz_hi_ff) begin
            sel_in = SEL_MAX;
         end else begin
            sel_in = SEL_QUOT;
         end
         // Dividend 2*MAX*(p-low) + d, divisor 2*d: rounds half up.
         num_in = NUM_W'(diff) * TWO_PM + NUM_W'(span);
         div_in = {span, 1'b0};
      end
      if (cmd.prep) begin
         // The upper part is below the divisor whenever the quotient fits in QW bits.
         rem_in = num_ff[NUM_W-1:QW];
         quo_in = num_ff[QW-1:0];
      end
      if (cmd.step) begin
         rem_in = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
      end
      if (cmd.emit) begin
         unique case (sel_ff)
            SEL_PASS: pixel_out_in = pix_ff;
            SEL_ZERO: pixel_out_in = '0;
            SEL_MAX:  pixel_out_in = MAX_OUT;
            SEL_QUOT: pixel_out_in = PIX_W'(quo_ff);
            default:  pixel_out_in = pix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_lo_ff  <= '1;
         run_hi_ff  <= '0;
         frz_lo_ff  <= '1;
         frz_hi_ff  <= '0;
         restart_ff <= 1'b1;
      end else begin
         run_lo_ff  <= run_lo_in;
         run_hi_ff  <= run_hi_in;
         frz_lo_ff  <= frz_lo_in;
         frz_hi_ff  <= frz_hi_in;
         restart_ff <= restart_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      sel_ff       <= sel_in;
      num_ff       <= num_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      pixel_out_ff <= pixel_out_in;
   end

   assign rsp_pixel_out = pixel_out_ff;

endmodule

`default_nettype wire

FILE: design/mmcs_ctrl.sv
// Controller of the contrast stretch: handshakes, sequencing of the divider
// and the result valid flag. Uses mmcs_pkg for the command struct.
`default_nettype none

module mmcs_ctrl #(
   parameter int PIXEL_MAX = 255
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_func,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output mmcs_pkg::mmcs_cmd_type      cmd
);
   import mmcs_pkg::*;

   localparam int QW    = $clog2(PIXEL_MAX + 1);
   localparam int CNT_W = $clog2(QW);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIVIDE, ST_EMIT} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, out_free;

   always_comb begin
      accept   = req_valid && (state_ff == ST_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;

      cmd.track = accept && !req_func;
      cmd.load  = accept && req_func;
      cmd.prep  = (state_ff == ST_PREP);
      cmd.step  = (state_ff == ST_DIVIDE);
      cmd.emit  = (state_ff == ST_EMIT) && out_free;

      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
            count_in = CNT_W'(QW - 1);
         end
         ST_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A waiting result leaves when the consumer stops stalling.
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // A map item reaches the emit state after the prep state and all divider steps.
   a_map_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ##(QW + 2) (state_ff == ST_EMIT))
      else $error("map item did not reach emit after the divider steps");

   // A result only appears as the consequence of an emit.
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result valid rose outside the emit state");

   // A result that is still stalled is never overwritten.
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.emit)
      else $error("emit while a stalled item waits in the output register");
`endif

endmodule

`default_nettype wire

FILE: design/min_max_contrast_stretch.sv
// Top level of the min/max contrast stretch for 8-bit grey frames.
// Instantiates mmcs_ctrl and mmcs_dp; uses mmcs_pkg.
//
// Each frame is sent twice. Measure items (func 0) track the lowest and highest
// pixel and give no result; the measure item with last set freezes that range for
// the map items that follow. Each map item (func 1) gives one stretched pixel,
// round((p-low)*PIXEL_MAX/(high-low)) with halves rounded up, 0 below the range,
// PIXEL_MAX (low 8 bits) at or above its top, and the pixel unchanged while the
// frozen range is flat or empty. A measure item is taken in the idle state; a map
// item stalls the input through the prep, divide and emit states, and the
// restoring divider produces one quotient bit per cycle. A result held by rsp_stall
// does not block the input, but the next map item then waits in its emit cycle,
// with the input stalled, until the output register is free.
`default_nettype none

module min_max_contrast_stretch #(
   parameter int PIXEL_MAX = 255
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_func,
   input  wire logic [mmcs_pkg::PIX_W-1:0] req_pixel,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [mmcs_pkg::PIX_W-1:0] rsp_pixel_out
);
   import mmcs_pkg::*;

   mmcs_cmd_type cmd;

   mmcs_ctrl #(
      .PIXEL_MAX (PIXEL_MAX)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mmcs_dp #(
      .PIXEL_MAX (PIXEL_MAX)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_pixel     (req_pixel),
      .req_last      (req_last),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule

`default_nettype wire

FILE: sim/min_max_contrast_stretch_test.sv
`timescale 1ns / 100ps
// Self-checking regression for min_max_contrast_stretch: directed rows, then random frames.
// Needs only the RTL (mmcs_pkg, mmcs_dp, mmcs_ctrl, top level) and checks every pixel_out
// against the want of its directed row or against a predictor built into this file.

module min_max_contrast_stretch_test;

   localparam int CLK_PERIOD = 4;
   localparam int PIX_MAX = 255;
   localparam int RANDOM_ITEMS = 560;
   localparam int TIMEOUT_NS = 2_000_000;

   localparam logic FUNC_MEASURE = 1'b0;
   localparam logic FUNC_MAP = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] pixel;
      logic       last;
      logic       known;
      logic [7:0] want;
   } stim_row_type;

   // Rows with known set carry their expected pixel_out; the others use the predictor.
   localparam int N_ROWS = 23;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{FUNC_MAP,     8'd0,   1'b0, 1'b1, 8'd0},    // no range frozen yet: pass-through
      '{FUNC_MAP,     8'd255, 1'b0, 1'b1, 8'd255},
      '{FUNC_MAP,     8'hA5,  1'b1, 1'b1, 8'hA5},   // last on a map item is ignored
      '{FUNC_MEASURE, 8'd200, 1'b1, 1'b0, 8'd0},    // single-pixel frame
      '{FUNC_MAP,     8'd17,  1'b0, 1'b1, 8'd17},   // flat range: pass-through
      '{FUNC_MEASURE, 8'd40,  1'b0, 1'b0, 8'd0},
      '{FUNC_MEASURE, 8'd200, 1'b0, 1'b0, 8'd0},
      '{FUNC_MEASURE, 8'd120, 1'b1, 1'b0, 8'd0},
      '{FUNC_MAP,     8'd39,  1'b0, 1'b1, 8'd0},    // below the frozen low
      '{FUNC_MAP,     8'd40,  1'b0, 1'b1, 8'd0},
      '{FUNC_MAP,     8'd200, 1'b0, 1'b1, 8'd255},
      '{FUNC_MAP,     8'd255, 1'b0, 1'b1, 8'd255},  // above the frozen high
      '{FUNC_MAP,     8'd120, 1'b0, 1'b0, 8'd0},
      '{FUNC_MEASURE, 8'd0,   1'b0, 1'b0, 8'd0},
      '{FUNC_MAP,     8'd160, 1'b0, 1'b0, 8'd0},    // map during a measure pass
      '{FUNC_MEASURE, 8'd255, 1'b1, 1'b0, 8'd0},
      '{FUNC_MAP,     8'd128, 1'b0, 1'b0, 8'd0},
      '{FUNC_MAP,     8'd1,   1'b0, 1'b0, 8'd0},
      '{FUNC_MEASURE, 8'd254, 1'b0, 1'b0, 8'd0},
      '{FUNC_MEASURE, 8'd255, 1'b1, 1'b0, 8'd0},
      '{FUNC_MAP,     8'd254, 1'b0, 1'b1, 8'd0},
      '{FUNC_MAP,     8'd255, 1'b0, 1'b1, 8'd255},
      '{FUNC_MAP,     8'd253, 1'b0, 1'b1, 8'd0}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [7:0] req_pixel;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_pixel_out;

   // Predictor state: the range being measured and the range frozen for mapping.
   logic [7:0] meas_low = 8'd255;
   logic [7:0] meas_high = 8'd0;
   logic       new_frame = 1'b1;
   logic [7:0] map_low = 8'd255;
   logic [7:0] map_high = 8'd0;

   logic [7:0] stretched_q [$];
   int         mismatch_count = 0;
   int         items_offered = 0;
   int         sink_hold_left = 0;
   bit         steady = 1'b0;

   min_max_contrast_stretch #(
      .PIXEL_MAX (PIX_MAX)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_pixel     (req_pixel),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] stretch_pixel(input logic [7:0] p);
      int lo;
      int hi;
      int d;
      int q;
      lo = map_low;
      hi = map_high;
      if (hi <= lo) return p;
      if (int'(p) < lo) return 8'd0;
      d = hi - lo;
      // Scale by PIX_MAX/d with halves rounded up, kept in exact integers.
      q = (2 * PIX_MAX * (int'(p) - lo) + d) / (2 * d);
      if (q > PIX_MAX) q = PIX_MAX;
      return q[7:0];
   endfunction

   // Offers one item, holds it until accepted, then updates the predictor.
   task automatic offer_item(input logic f, input logic [7:0] p, input logic l,
                             input logic known, input logic [7:0] want);
      int gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= f;
      req_pixel <= p;
      req_last <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_offered++;
      if (f == FUNC_MAP) begin
         stretched_q.push_back(known ? want : stretch_pixel(p));
      end else begin
         if (new_frame) begin
            meas_low = p;
            meas_high = p;
            new_frame = 1'b0;
         end else begin
            if (p < meas_low) meas_low = p;
            if (p > meas_high) meas_high = p;
         end
         if (l) begin
            map_low = meas_low;
            map_high = meas_high;
            new_frame = 1'b1;
         end
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (stretched_q.size() != 0) @(posedge clock);
   endtask

   // One frame: a measure pass over a random band, then a map pass, with some noise.
   task automatic send_frame();
      int n_meas;
      int n_map;
      int base;
      int span;
      int top;
      int r;
      int p;
      bit drop_last;
      r = $urandom_range(0, 99);
      if (r < 10) n_meas = 1;
      else if (r < 75) n_meas = $urandom_range(2, 8);
      else if (r < 95) n_meas = $urandom_range(9, 24);
      else n_meas = $urandom_range(25, 40);
      base = $urandom_range(0, 255);
      r = $urandom_range(0, 99);
      if (r < 10) span = 0;
      else if (r < 30) span = $urandom_range(1, 8);
      else span = $urandom_range(0, 255);
      top = (base + span > 255) ? 255 : base + span;
      // Now and then a frame never gets its last flag, so tracking runs on.
      drop_last = ($urandom_range(0, 99) < 5);
      for (int k = 0; k < n_meas; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            offer_item(FUNC_MAP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, 8'd0);
         end
         offer_item(FUNC_MEASURE, 8'($urandom_range(base, top)),
                    (k == n_meas - 1) && !drop_last, 1'b0, 8'd0);
      end
      n_map = $urandom_range(1, n_meas + 4);
      for (int k = 0; k < n_map; k++) begin
         if ($urandom_range(0, 99) < 70) begin
            p = $urandom_range((base < 4) ? 0 : base - 4, (top > 251) ? 255 : top + 4);
         end else begin
            p = $urandom_range(0, 255);
         end
         offer_item(FUNC_MAP, 8'(p), ($urandom_range(0, 99) < 10), 1'b0, 8'd0);
      end
   endtask

   // Result side: random stall runs, stall-free stretches, and a long hold when asked.
   initial begin
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_left > 0) begin
            rsp_stall <= 1'b1;
            sink_hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (steady) begin
               free_left = 20;
            end else begin
               stall_left = idle_len();
               free_left = idle_len() + $urandom_range(0, 4);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stretched_q.size() == 0) begin
            $display("%0t: pixel_out %0d arrived with no result expected", $time,
                     rsp_pixel_out);
            mismatch_count++;
         end else if (rsp_pixel_out !== stretched_q[0]) begin
            $display("%0t: pixel_out expected %0d, got %0d", $time, stretched_q[0],
                     rsp_pixel_out);
            mismatch_count++;
            void'(stretched_q.pop_front());
         end else begin
            void'(stretched_q.pop_front());
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_MEASURE;
      req_pixel = 8'd0;
      req_last = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         offer_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].last,
                    DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
      end
      wait_for_drain();

      // Hold the result side off for a long while and keep offering map items, so the
      // block backs up and stalls its input.
      sink_hold_left = 300;
      steady = 1'b1;
      for (int i = 0; i < 40; i++) begin
         offer_item(FUNC_MAP, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'd0);
      end
      steady = 1'b0;
      wait_for_drain();

      while (items_offered < N_ROWS + 40 + RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 99) < 15);
         send_frame();
         if ($urandom_range(0, 99) < 25) wait_for_drain();
      end
      steady = 1'b0;
      wait_for_drain();
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("min_max_contrast_stretch regression: pass");
      end else begin
         $display("min_max_contrast_stretch regression: fail");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("min_max_contrast_stretch regression: fail");
      $finish;
   end

endmodule

FILE: files.f
design/mmcs_pkg.sv
design/mmcs_dp.sv
design/mmcs_ctrl.sv
design/min_max_contrast_stretch.sv
sim/min_max_contrast_stretch_test.sv
